// ----- hdl/lbcm_pkg.sv -----
// Package for the linear battery charge model: item, job and register types,
// fixed point constants and a saturation helper.
// No dependencies; every other file in hdl/ uses it.
`default_nettype none
package lbcm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;
  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int WIDE_W    = 50;

  localparam logic [63:0] NS_PER_S   = 64'd1000000000;
  localparam logic [63:0] NS_PER_HR  = 64'd3600000000000;
  localparam logic [41:0] MV_PER_V   = 42'd1000;
  localparam logic [31:0] MAX32      = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32_MAG  = 32'h8000_0000;

  // ns per hour = 2^DQ_SHIFT * DQ_ODD; charge drop divides by DQ_ODD through
  // a reciprocal scaled by 2^60
  localparam int          DQ_SHIFT = 13;
  localparam logic [31:0] DQ_ODD   = 32'(NS_PER_HR >> DQ_SHIFT);
  localparam logic [31:0] DQ_RECIP = 32'((64'd1 << 60) / 64'(DQ_ODD));

  // register indexes on the configuration port
  localparam logic [2:0] REG_E0  = 3'd0;
  localparam logic [2:0] REG_E1  = 3'd1;
  localparam logic [2:0] REG_Q0  = 3'd2;
  localparam logic [2:0] REG_CAP = 3'd3;
  localparam logic [2:0] REG_RES = 3'd4;
  localparam logic [2:0] REG_TAU = 3'd5;

  typedef struct packed {
    logic signed [31:0] load_power;
    logic               last_load;
    logic signed [31:0] battery_voltage;
    logic [29:0]        step_ns;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] terminal_voltage;
    logic signed [31:0] smoothed_current;
    logic signed [31:0] raw_current;
    logic signed [31:0] charge_left;
    logic               voltage_too_low;
  } out_item_t;

  // one closed time step, handed from front to back
  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] total;
    logic signed [31:0]          volt;
    logic [29:0]                 step;
  } job_t;

  typedef struct packed {
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic [30:0]        q0;
    logic [30:0]        cap;
    logic [30:0]        res;
    logic [30:0]        tau;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_IRAW_WAIT, ST_K_START, ST_K_WAIT, ST_FILT_MUL,
    ST_FILT_UPD, ST_DQ_MUL, ST_DQ_REC, ST_DQ_EST, ST_DQ_FIX, ST_RATIO_START,
    ST_RATIO_WAIT, ST_T1_MUL, ST_T2_MUL, ST_VOUT, ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'({1'b0, MAX32}));
    lo = -hi - WIDE_W'(1);
    if (v > hi)      return signed'(MAX32);
    else if (v < lo) return signed'(MIN32_MAG);
    else             return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lbcm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on lbcm_pkg.
`default_nettype none
module lbcm_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lbcm_pkg::DIV_W-1:0] num,
  input  wire logic [lbcm_pkg::DIV_W-1:0] den,
  output logic                          busy,
  output logic                          done,
  output logic [lbcm_pkg::DIV_W-1:0]    quo
);
  logic [lbcm_pkg::DIV_W-1:0]     rem;
  logic [lbcm_pkg::DIV_W-1:0]     dsr;
  logic [lbcm_pkg::DIV_CNT_W-1:0] cnt;
  logic [lbcm_pkg::DIV_W:0]       rem_sh;
  logic [lbcm_pkg::DIV_W:0]       diff;
  logic                           ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[lbcm_pkg::DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lbcm_pkg::DIV_CNT_W'(lbcm_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - lbcm_pkg::DIV_CNT_W'(1);
        if (cnt == lbcm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? diff[lbcm_pkg::DIV_W-1:0] : rem_sh[lbcm_pkg::DIV_W-1:0];
      quo <= {quo[lbcm_pkg::DIV_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/lbcm_fifo.sv -----
// Two-entry job queue between the front and the back.
// Depends on lbcm_pkg.
`default_nettype none
module lbcm_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lbcm_pkg::job_t push_job,
  input  wire logic           pop,
  output lbcm_pkg::job_t      head,
  output logic                full,
  output logic                empty
);
  lbcm_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end
endmodule
`default_nettype wire

// ----- hdl/lbcm_front.sv -----
// Front: takes load beats, keeps the saturating power sum, queues a job
// on each last load. Depends on lbcm_pkg.
`default_nettype none
module lbcm_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lbcm_pkg::in_item_t in_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output lbcm_pkg::job_t          q_job
);
  logic signed [lbcm_pkg::SUM_WIDTH-1:0] power_sum;
  logic signed [lbcm_pkg::SUM_WIDTH-1:0] power_sum_next;
  logic signed [lbcm_pkg::SUM_WIDTH:0]   ext;
  logic                                  take;

  // a last load needs a free queue slot
  assign in_ready = !in_data.last_load || !q_full;
  assign take     = in_valid && in_ready;
  assign q_push   = take && in_data.last_load;

  // saturating accumulate
  always_comb begin
    ext = {power_sum[lbcm_pkg::SUM_WIDTH-1], power_sum}
        + (lbcm_pkg::SUM_WIDTH+1)'(in_data.load_power);
    if (ext[lbcm_pkg::SUM_WIDTH] != ext[lbcm_pkg::SUM_WIDTH-1])
      power_sum_next = ext[lbcm_pkg::SUM_WIDTH]
        ? {1'b1, {(lbcm_pkg::SUM_WIDTH-1){1'b0}}}
        : {1'b0, {(lbcm_pkg::SUM_WIDTH-1){1'b1}}};
    else
      power_sum_next = ext[lbcm_pkg::SUM_WIDTH-1:0];
    q_job.total = power_sum_next;
    q_job.volt  = in_data.battery_voltage;
    q_job.step  = in_data.step_ns;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_sum <= '0;
    end else if (take) begin
      power_sum <= in_data.last_load ? '0 : power_sum_next;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/lbcm_back.sv -----
// Back: sequencer that turns one queued step into a result, using the
// shared divider and one registered multiplier. Depends on lbcm_pkg, lbcm_div.
`default_nettype none
module lbcm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lbcm_pkg::cfg_regs_t cfg,
  input  wire logic                q0_load,
  input  wire logic [30:0]         q0_value,
  input  wire lbcm_pkg::job_t      q_head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lbcm_pkg::out_item_t      out_data
);
  localparam int F = lbcm_pkg::FRAC_BITS;
  localparam int W = lbcm_pkg::WIDE_W;

  lbcm_pkg::state_t    state, state_next;
  lbcm_pkg::job_t      job;
  lbcm_pkg::out_item_t res;
  logic signed [31:0]  iraw, fc, charge, ratio;
  logic [31:0]         k;
  logic signed [W-1:0] t1;
  logic [64:0]         prod;

  logic                div_start, div_busy, div_done;
  logic [63:0]         div_num, div_den, quo;
  logic [31:0]         mul_a;
  logic [32:0]         mul_b;

  logic [31:0]         vmag, fcmag, chmag, e1mag, qmax, qmin;
  logic [lbcm_pkg::SUM_WIDTH-1:0] tmag;
  logic                low;
  logic signed [32:0]  diff, omr;
  logic [32:0]         dmag, omag;
  logic signed [W-1:0] ps;
  logic [47:0]         dq_y, dq_rem;
  logic [19:0]         dq_q;
  logic signed [W-1:0] dq_amt;

  lbcm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(quo)
  );

  // magnitudes and clamps
  always_comb begin
    vmag  = job.volt[31] ? 32'(-job.volt) : 32'(job.volt);
    tmag  = job.total[lbcm_pkg::SUM_WIDTH-1] ? lbcm_pkg::SUM_WIDTH'(-job.total)
                                             : lbcm_pkg::SUM_WIDTH'(job.total);
    low   = ({10'd0, vmag} * lbcm_pkg::MV_PER_V) < (42'd1 << F);
    fcmag = fc[31] ? 32'(-fc) : 32'(fc);
    chmag = charge[31] ? 32'(-charge) : 32'(charge);
    e1mag = cfg.e1[31] ? 32'(-cfg.e1) : 32'(cfg.e1);
    diff  = {iraw[31], iraw} - {fc[31], fc};
    dmag  = diff[32] ? 33'(-diff) : 33'(diff);
    omr   = (33'sd1 <<< F) - {ratio[31], ratio};
    omag  = omr[32] ? 33'(-omr) : 33'(omr);
    qmax  = (quo > 64'(lbcm_pkg::MAX32)) ? lbcm_pkg::MAX32 : quo[31:0];
    qmin  = (quo > 64'(lbcm_pkg::MIN32_MAG)) ? lbcm_pkg::MIN32_MAG : quo[31:0];
    ps    = W'(prod[64:F]);
    // estimate is at most one low; the remainder settles it
    dq_rem = dq_y - prod[47:0];
    dq_amt = W'(dq_q) + W'(dq_rem >= 48'(lbcm_pkg::DQ_ODD));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lbcm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state, divider and multiplier operands
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      lbcm_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = lbcm_pkg::ST_CHECK;
        end
      end
      lbcm_pkg::ST_CHECK: begin
        if (low) begin
          state_next = lbcm_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          div_num    = 64'(tmag) << F;
          div_den    = 64'(vmag);
          state_next = lbcm_pkg::ST_IRAW_WAIT;
        end
      end
      lbcm_pkg::ST_IRAW_WAIT: if (div_done) state_next = lbcm_pkg::ST_K_START;
      lbcm_pkg::ST_K_START: begin
        if (cfg.tau == '0) begin
          state_next = lbcm_pkg::ST_FILT_MUL;
        end else begin
          div_start  = 1'b1;
          div_num    = 64'(job.step) << (2 * F);
          div_den    = 64'(cfg.tau) * lbcm_pkg::NS_PER_S;
          state_next = lbcm_pkg::ST_K_WAIT;
        end
      end
      lbcm_pkg::ST_K_WAIT: if (div_done) state_next = lbcm_pkg::ST_FILT_MUL;
      lbcm_pkg::ST_FILT_MUL: begin
        mul_a      = k;
        mul_b      = dmag;
        state_next = lbcm_pkg::ST_FILT_UPD;
      end
      lbcm_pkg::ST_FILT_UPD: state_next = lbcm_pkg::ST_DQ_MUL;
      lbcm_pkg::ST_DQ_MUL: begin
        mul_a      = 32'(job.step);
        mul_b      = 33'(fcmag);
        state_next = lbcm_pkg::ST_DQ_REC;
      end
      // quotient estimate from the top 32 bits of product >> DQ_SHIFT
      lbcm_pkg::ST_DQ_REC: begin
        mul_a      = lbcm_pkg::DQ_RECIP;
        mul_b      = 33'(prod[60:29]);
        state_next = lbcm_pkg::ST_DQ_EST;
      end
      lbcm_pkg::ST_DQ_EST: begin
        mul_a      = lbcm_pkg::DQ_ODD;
        mul_b      = 33'(prod[63:44]);
        state_next = lbcm_pkg::ST_DQ_FIX;
      end
      lbcm_pkg::ST_DQ_FIX: state_next = lbcm_pkg::ST_RATIO_START;
      lbcm_pkg::ST_RATIO_START: begin
        if (cfg.cap == '0) begin
          state_next = lbcm_pkg::ST_T1_MUL;
        end else begin
          div_start  = 1'b1;
          div_num    = 64'(chmag) << F;
          div_den    = 64'(cfg.cap);
          state_next = lbcm_pkg::ST_RATIO_WAIT;
        end
      end
      lbcm_pkg::ST_RATIO_WAIT: if (div_done) state_next = lbcm_pkg::ST_T1_MUL;
      lbcm_pkg::ST_T1_MUL: begin
        mul_a      = e1mag;
        mul_b      = omag;
        state_next = lbcm_pkg::ST_T2_MUL;
      end
      lbcm_pkg::ST_T2_MUL: begin
        mul_a      = 32'(cfg.res);
        mul_b      = 33'(fcmag);
        state_next = lbcm_pkg::ST_VOUT;
      end
      lbcm_pkg::ST_VOUT: state_next = lbcm_pkg::ST_DONE;
      lbcm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = lbcm_pkg::ST_IDLE;
      end
      default: state_next = lbcm_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= {33'd0, mul_a} * {32'd0, mul_b};
    if (rst) begin
      fc     <= '0;
      charge <= '0;
    end else begin
      case (state)
        lbcm_pkg::ST_IDLE: job <= q_head;
        lbcm_pkg::ST_CHECK: begin
          res.terminal_voltage <= '0;
          res.smoothed_current <= fc;
          res.raw_current      <= '0;
          res.charge_left      <= charge;
          res.voltage_too_low  <= 1'b1;
        end
        lbcm_pkg::ST_IRAW_WAIT: begin
          // sign of quotient follows both operands; clamp edge differs by side
          if (job.total[lbcm_pkg::SUM_WIDTH-1] == job.volt[31])
            iraw <= signed'(qmax);
          else if (job.total[lbcm_pkg::SUM_WIDTH-1])
            iraw <= signed'(32'(-qmin));
          else
            iraw <= signed'(32'(-qmax));
        end
        lbcm_pkg::ST_K_START: k <= 32'd1 << F;
        lbcm_pkg::ST_K_WAIT: k <= qmax;
        lbcm_pkg::ST_FILT_UPD:
          fc <= lbcm_pkg::sat32(W'(fc) + (diff[32] ? -ps : ps));
        lbcm_pkg::ST_DQ_REC: dq_y <= prod[60:13];
        lbcm_pkg::ST_DQ_EST: dq_q <= prod[63:44];
        lbcm_pkg::ST_DQ_FIX:
          charge <= lbcm_pkg::sat32(W'(charge) - (fc[31] ? -dq_amt : dq_amt));
        lbcm_pkg::ST_RATIO_START: ratio <= '0;
        lbcm_pkg::ST_RATIO_WAIT: ratio <= charge[31] ? signed'(32'(-qmax)) : signed'(qmax);
        lbcm_pkg::ST_T2_MUL: t1 <= (cfg.e1[31] ^ omr[32]) ? -ps : ps;
        lbcm_pkg::ST_VOUT: begin
          res.terminal_voltage <= lbcm_pkg::sat32(W'(cfg.e0) + t1 - (fc[31] ? -ps : ps));
          res.smoothed_current <= fc;
          res.raw_current      <= iraw;
          res.charge_left      <= charge;
          res.voltage_too_low  <= 1'b0;
        end
        default: ;
      endcase
      if (q0_load) charge <= signed'({1'b0, q0_value});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == lbcm_pkg::ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.voltage_too_low |->
      out_data.terminal_voltage == '0 && out_data.raw_current == '0)
    else $error("low voltage result carries nonzero values");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == lbcm_pkg::ST_IDLE |-> !div_busy)
    else $error("divider busy with no step in work");
endmodule
`default_nettype wire

// ----- hdl/linear_battery_charge_model_top.sv -----
// Top level of the linear battery charge model: configuration registers,
// front, job queue and back. Depends on lbcm_pkg and all lbcm_* modules.
//
// Each load beat is summed into a saturating power sum. A beat with
// last_load set closes the step and queues it (two steps can wait); the
// back then computes raw current, smoothed current, charge and terminal
// voltage in signed Q16.16 and delivers one result beat. A closed step
// makes up to three passes through the shared 64-bit divider at one
// quotient bit per cycle; the charge drop uses a short reciprocal multiply.
// A step below 1 mV skips the update and delivers the state unchanged with
// voltage_too_low set. Load beats keep being accepted while the back works,
// unless a last load finds the queue full.
`default_nettype none
module linear_battery_charge_model_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lbcm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lbcm_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  lbcm_pkg::cfg_regs_t cfg;
  lbcm_pkg::job_t      q_job, q_head;
  logic                q_push, q_pop, q_full, q_empty, cfg_wr, q0_load;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign q0_load   = cfg_wr && cfg_index == lbcm_pkg::REG_Q0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        lbcm_pkg::REG_E0:  cfg.e0  <= cfg_data;
        lbcm_pkg::REG_E1:  cfg.e1  <= cfg_data;
        lbcm_pkg::REG_Q0:  cfg.q0  <= cfg_data[30:0];
        lbcm_pkg::REG_CAP: cfg.cap <= cfg_data[30:0];
        lbcm_pkg::REG_RES: cfg.res <= cfg_data[30:0];
        lbcm_pkg::REG_TAU: cfg.tau <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  lbcm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_full(q_full), .q_push(q_push), .q_job(q_job)
  );

  lbcm_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .push_job(q_job), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  lbcm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q0_load(q0_load), .q0_value(cfg_data[30:0]),
    .q_head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

// ----- tb/linear_battery_charge_model_top_tb.sv -----
// Self-checking testbench for linear_battery_charge_model_top.
// Uses lbcm_pkg for the beat types and register indexes; needs only the RTL.
`timescale 1ns / 1ps
module linear_battery_charge_model_top_tb;

  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam longint SUM_HI      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ONE_Q       = 64'sd65536;
  localparam int     WATCH_LIMIT = 20000;
  localparam int     LONG_HOLD   = 400;
  localparam logic [2:0] REG_NONE = 3'd6;

  // Expected-result store plus a bit-accurate copy of the charge model
  class battery_scoreboard;
    longint e0, e1, q0, cap, res, tau;
    longint psum, filt, charge;
    lbcm_pkg::out_item_t expected_steps[$];
    int failures, steps_checked, low_steps, loads_seen;

    function new();
      e0 = 0; e1 = 0; q0 = 0; cap = 0; res = 0; tau = 0;
      psum = 0; filt = 0; charge = 0;
      failures = 0; steps_checked = 0; low_steps = 0; loads_seen = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function longint sat32(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // a * 2^s / b, truncated, clipped at lim
    function longint unsigned div_fix(longint unsigned a, longint unsigned b, int s,
                                      longint unsigned lim);
      longint unsigned q, r;
      q = a / b;
      r = a % b;
      if (q > lim) return lim;
      for (int i = 0; i < s; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= b) begin
          r = r - b;
          q = q | 1;
        end
        if (q > lim) return lim;
      end
      return q;
    endfunction

    function longint mul_fix(longint a, longint b);
      longint unsigned p;
      p = (mag(a) * mag(b)) >> lbcm_pkg::FRAC_BITS;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint signed_div(longint a, longint unsigned b, int s);
      if (a < 0) return -longint'(div_fix(mag(a), b, s, 64'd2147483648));
      return longint'(div_fix(a, b, s, 64'd2147483647));
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        lbcm_pkg::REG_E0:  e0 = longint'(signed'(data));
        lbcm_pkg::REG_E1:  e1 = longint'(signed'(data));
        lbcm_pkg::REG_Q0: begin
          q0 = longint'({33'd0, data[30:0]});
          charge = q0;
        end
        lbcm_pkg::REG_CAP: cap = longint'({33'd0, data[30:0]});
        lbcm_pkg::REG_RES: res = longint'({33'd0, data[30:0]});
        lbcm_pkg::REG_TAU: tau = longint'({33'd0, data[30:0]});
        default: ;
      endcase
    endfunction

    // accepted load beat; a last load closes the step and yields one result
    function void note_load(lbcm_pkg::in_item_t it);
      longint ld, volt, total, iraw, k, delta, ratio, t1, t2, vout;
      longint unsigned stp;
      lbcm_pkg::out_item_t r;
      ld = it.load_power;
      volt = it.battery_voltage;
      stp = {34'd0, it.step_ns};
      loads_seen++;
      if (ld > 0 && psum > SUM_HI - ld) psum = SUM_HI;
      else if (ld < 0 && psum < -SUM_HI - 1 - ld) psum = -SUM_HI - 1;
      else psum = psum + ld;
      if (!it.last_load) return;
      total = psum;
      psum = 0;
      r = '0;
      // below 1 mV: no update, state shown unchanged
      if (mag(volt) * 1000 < 64'd65536) begin
        r.smoothed_current = filt[31:0];
        r.charge_left = charge[31:0];
        r.voltage_too_low = 1'b1;
        low_steps++;
        expected_steps.push_back(r);
        return;
      end
      iraw = signed_div(total, mag(volt), lbcm_pkg::FRAC_BITS);
      if (volt < 0) iraw = sat32(-iraw);
      if (tau == 0) k = ONE_Q;
      else k = longint'(div_fix(stp, 64'd1000000000 * longint'(tau),
                                2 * lbcm_pkg::FRAC_BITS, 64'd2147483647));
      filt = sat32(filt + mul_fix(k, iraw - filt));
      delta = longint'((stp * mag(filt)) / 64'd3600000000000);
      if (filt < 0) delta = -delta;
      charge = sat32(charge - delta);
      ratio = (cap == 0) ? 0 : sat32(signed_div(charge, cap, lbcm_pkg::FRAC_BITS));
      if (ratio < -SAT_HI) ratio = -SAT_HI;
      t1 = mul_fix(e1, ONE_Q - ratio);
      t2 = mul_fix(res, filt);
      vout = sat32(e0 + t1 - t2);
      r.terminal_voltage = vout[31:0];
      r.smoothed_current = filt[31:0];
      r.raw_current = iraw[31:0];
      r.charge_left = charge[31:0];
      expected_steps.push_back(r);
    endfunction

    function void check_result(lbcm_pkg::out_item_t got);
      lbcm_pkg::out_item_t want;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        failures++;
        return;
      end
      want = expected_steps.pop_front();
      steps_checked++;
      if (got.terminal_voltage !== want.terminal_voltage) begin
        $display("%0t: terminal_voltage exp %h got %h", $time,
                 want.terminal_voltage, got.terminal_voltage);
        failures++;
      end
      if (got.smoothed_current !== want.smoothed_current) begin
        $display("%0t: smoothed_current exp %h got %h", $time,
                 want.smoothed_current, got.smoothed_current);
        failures++;
      end
      if (got.raw_current !== want.raw_current) begin
        $display("%0t: raw_current exp %h got %h", $time,
                 want.raw_current, got.raw_current);
        failures++;
      end
      if (got.charge_left !== want.charge_left) begin
        $display("%0t: charge_left exp %h got %h", $time,
                 want.charge_left, got.charge_left);
        failures++;
      end
      if (got.voltage_too_low !== want.voltage_too_low) begin
        $display("%0t: voltage_too_low exp %b got %b", $time,
                 want.voltage_too_low, got.voltage_too_low);
        failures++;
      end
    endfunction
  endclass

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  lbcm_pkg::in_item_t  in_data;
  lbcm_pkg::out_item_t out_data;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  battery_scoreboard sb;
  int tx_idle_pct, rx_idle_pct;
  bit long_hold;
  int quiet_cycles;
  int settings_used;

  linear_battery_charge_model_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // check every result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, sb.expected_steps.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_load(lbcm_pkg::in_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_load(it);
  endtask

  // sender stops and waits for every outstanding step to come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(int sel);
    logic [31:0] v[6];
    case (sel)
      0: v = '{32'h0003_B333, 32'h0000_8000, 32'h0002_0000, 32'h0002_8000,
               32'h0000_0CCD, 32'h0002_0000};
      1: v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
               32'h7FFF_FFFF, 32'h0000_0001};
      2: v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      default: v = '{$urandom, $urandom, $urandom_range(32'h0010_0000),
                     32'h0, $urandom_range(32'h0001_0000), 32'h0};
    endcase
    write_reg(lbcm_pkg::REG_E0, v[0]);
    write_reg(lbcm_pkg::REG_E1, v[1]);
    write_reg(lbcm_pkg::REG_Q0, v[2]);
    write_reg(lbcm_pkg::REG_CAP, v[3]);
    write_reg(lbcm_pkg::REG_RES, v[4]);
    write_reg(lbcm_pkg::REG_TAU, v[5]);
    if (sel == 3) write_reg(REG_NONE, $urandom);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic lbcm_pkg::in_item_t rand_load(bit last);
    lbcm_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(15);
    it.load_power = (pick == 0) ? $urandom : $urandom_range(32'h0064_0000) - 32'h0014_0000;
    it.last_load = last;
    if (pick == 1) it.battery_voltage = $urandom;
    else if (pick == 2) it.battery_voltage = $urandom_range(130) - 65;
    else if (pick == 3) it.battery_voltage = -$urandom_range(32'h000C_0000, 32'h0001_0000);
    else it.battery_voltage = $urandom_range(32'h001E_0000, 32'h0006_0000);
    it.step_ns = ($urandom_range(7) == 0) ? $urandom_range(1000000000)
                                          : $urandom_range(20000000, 1000000);
    return it;
  endfunction

  function automatic lbcm_pkg::in_item_t mk(logic [31:0] p, bit last, logic [31:0] v,
                                            logic [29:0] s);
    lbcm_pkg::in_item_t it;
    it.load_power = p;
    it.last_load = last;
    it.battery_voltage = v;
    it.step_ns = s;
    return it;
  endfunction

  initial begin
    int n, len;
    sb = new();
    settings_used = 0;
    quiet_cycles = 0;
    long_hold = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, low voltage, zero tau and capacity at reset
    send_load(mk(32'h7FFF_FFFF, 1, 32'h0001_0000, 30'd1000000000));
    send_load(mk(32'h8000_0000, 1, 32'h0001_0000, 30'd0));
    send_load(mk(32'h0010_0000, 0, 32'h0001_0000, 30'd5000000));
    send_load(mk(32'hFFF0_0000, 0, 32'h0001_0000, 30'd5000000));
    send_load(mk(32'h0005_0000, 1, 32'hFFFF_0000, 30'd5000000));
    send_load(mk(32'h0001_0000, 1, 32'h8000_0000, 30'd1000000000));
    send_load(mk(32'h0001_0000, 1, 32'h7FFF_FFFF, 30'h3FFF_FFFF & 30'd999999999));
    send_load(mk(32'h0003_0000, 1, 32'd65, 30'd1000000));
    send_load(mk(32'h0003_0000, 1, 32'd66, 30'd1000000));
    send_load(mk(32'h0003_0000, 1, -32'sd65, 30'd1000000));
    send_load(mk(32'h0003_0000, 1, -32'sd66, 30'd1000000));
    send_load(mk(32'h0003_0000, 1, 32'd0, 30'd1000000));
    wait_quiet();
    apply_settings(0);
    send_load(mk(32'h7FFF_FFFF, 0, 32'h0004_0000, 30'd1000000000));
    send_load(mk(32'h7FFF_FFFF, 1, 32'h0004_0000, 30'd1000000000));
    send_load(mk(32'h8000_0000, 1, 32'h0000_0042, 30'd1000000000));
    send_load(mk(32'h0000_0000, 1, 32'h0004_0000, 30'd0));
    wait_quiet();
    apply_settings(1);
    send_load(mk(32'h0100_0000, 1, 32'h0001_0000, 30'd1000000000));
    send_load(mk(32'hFF00_0000, 1, 32'hFFFF_0000, 30'd1000000000));
    send_load(mk(32'h7FFF_FFFF, 1, 32'h0000_0100, 30'd1000000000));

    // random steps in three back-pressure phases, settings rotating
    for (int slot = 0; slot < 9; slot++) begin
      case (slot / 3)
        0: begin tx_idle_pct = 36; rx_idle_pct = 51; end
        1: begin tx_idle_pct = 51; rx_idle_pct = 36; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      wait_quiet();
      apply_settings((slot + 2) % 4);
      if (slot == 7) long_hold = 1'b1;
      n = 0;
      while (n < 180) begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) send_load(rand_load(j == len - 1));
        n += len;
      end
    end

    wait_quiet();
    repeat (300) @(posedge clk);
    $display("Covered %0d load beats, %0d step results (%0d below 1 mV), %0d settings.",
             sb.loads_seen, sb.steps_checked, sb.low_steps, settings_used);
    if (sb.failures == 0 && sb.expected_steps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.failures,
               sb.expected_steps.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lbcm_pkg.sv
hdl/lbcm_div.sv
hdl/lbcm_fifo.sv
hdl/lbcm_front.sv
hdl/lbcm_back.sv
hdl/linear_battery_charge_model_top.sv
tb/linear_battery_charge_model_top_tb.sv
